/* rtl/stm_pkg.sv */
// Shared types and constants for the sparse-table range-minimum engine.
// Depends on nothing; every other file imports it.
package stm_pkg;

  localparam int DEPTH_DEF  = 1024;
  localparam int LEVELS_DEF = 11;

  localparam int VAL_W = 32;
  localparam int IDX_W = 10;
  // Bits needed to hold floor(log2) of a range length of up to 2^IDX_W.
  localparam int LGW   = $clog2(IDX_W + 1);

  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;
    logic query;
    logic qload;
    logic bld_start;
    logic bld_step;
    logic next_level;
    logic bld_done;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic lvl_ok;
    logic lvl_last;
  } dp_stat_t;

endpackage

/* rtl/stm_in_if.sv */
// Input channel of the range-minimum engine: push and query items.
// Depends on stm_pkg for field widths.
interface stm_in_if import stm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [VAL_W-1:0] value;
  logic                    last;
  logic [IDX_W-1:0]        left;
  logic [IDX_W-1:0]        right;

  modport source (output valid, func, value, last, left, right, input ready);
  modport sink   (input valid, func, value, last, left, right, output ready);
endinterface

/* rtl/stm_out_if.sv */
// Result channel of the range-minimum engine.
// Depends on stm_pkg for field widths.
interface stm_out_if import stm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] min_value;
  logic                    error;

  modport source (output valid, min_value, error, input ready);
  modport sink   (input valid, min_value, error, output ready);
endinterface

/* rtl/stm_ctrl.sv */
// Controller of the range-minimum engine: accepts items and sequences the build.
// Depends on stm_pkg for the command and status structs.
module stm_ctrl import stm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_func,
  input  logic     in_last,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_QRES  = 2'd1;
  localparam logic [1:0] S_BUILD = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          if (in_func == FUNC_QUERY) begin
            cmd.query = 1'b1;
            state_nxt = S_QRES;
          end else begin
            cmd.push = 1'b1;
            if (in_last) begin
              cmd.bld_start = 1'b1;
              state_nxt     = S_BUILD;
            end
          end
        end
      end
      S_QRES: begin
        cmd.qload = 1'b1;
        state_nxt = S_IDLE;
      end
      S_BUILD: begin
        if (!stat.lvl_ok) begin
          cmd.bld_done = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.bld_step = 1'b1;
          if (stat.lvl_last) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        // The last write of the level lands here, before the next level reads it.
        cmd.next_level = 1'b1;
        state_nxt      = S_BUILD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/stm_datapath.sv */
// Datapath of the range-minimum engine: table memory, counters, query logic, output register.
// Depends on stm_pkg for widths and the command and status structs.
module stm_datapath import stm_pkg::*; #(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctl_cmd_t                cmd,
  output dp_stat_t                stat,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [IDX_W-1:0]        in_left,
  input  logic [IDX_W-1:0]        in_right,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_min_value,
  output logic                    out_error
);

  localparam int MEM_N = LEVELS * DEPTH;
  localparam int AW    = $clog2(MEM_N);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);
  localparam int KW    = $clog2(LEVELS + 1);
  localparam int LW    = (CW > IDX_W) ? CW : IDX_W;

  logic signed [VAL_W-1:0] mem [MEM_N];

  logic [CW-1:0]           count_r, count_nxt;
  logic                    tbl_ready_r, tbl_ready_nxt;
  logic [KW-1:0]           lvl_r, lvl_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic                    wpend_r;
  logic [AW-1:0]           wr_addr_r;
  logic                    qerr_r;
  logic signed [VAL_W-1:0] rd_a_r, rd_b_r;
  logic signed [VAL_W-1:0] rd_min;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_min_value_r;
  logic                    out_error_r;

  // Push side.
  logic [CW-1:0]           push_idx;
  logic                    push_room;

  // Build side.
  logic [CW-1:0]           pow_k;
  logic [AW-1:0]           bld_base;
  logic [AW-1:0]           bld_half;
  logic [AW-1:0]           bld_a, bld_b, bld_w;

  // Query side.
  logic                    q_err;
  logic [IDX_W:0]          q_len;
  logic [LGW-1:0]          q_lg;
  logic [KW-1:0]           q_k;
  logic [AW-1:0]           q_base;
  logic [AW-1:0]           q_a, q_b;

  // Memory port control.
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic signed [VAL_W-1:0] mem_wd;
  logic                    mem_re;
  logic [AW-1:0]           mem_ra, mem_rb;

  assign rd_min = (rd_b_r < rd_a_r) ? rd_b_r : rd_a_r;

  // A push after a finished build starts a new array at index zero.
  assign push_idx  = tbl_ready_r ? '0 : count_r;
  assign push_room = (push_idx < CW'(DEPTH));

  assign pow_k    = CW'(1) << lvl_r;
  assign bld_base = AW'(lvl_r - KW'(1)) * AW'(DEPTH);
  assign bld_half = AW'(1) << (lvl_r - KW'(1));
  assign bld_a    = bld_base + AW'(idx_r);
  assign bld_b    = bld_a + bld_half;
  assign bld_w    = bld_a + AW'(DEPTH);

  assign stat.lvl_ok   = (int'(lvl_r) < LEVELS) && ((count_r >> lvl_r) != '0);
  assign stat.lvl_last = ((CW'(idx_r) + pow_k) == count_r);
  assign stat.out_free = !out_valid_r || out_ready;

  assign q_err = !tbl_ready_r || (in_left > in_right) || (LW'(in_right) >= LW'(count_r));
  assign q_len = {1'b0, in_right} - {1'b0, in_left} + (IDX_W + 1)'(1);

  always_comb begin
    q_lg = '0;
    for (int j = 1; j <= IDX_W; j++) begin
      if (q_len[j]) begin
        q_lg = LGW'(j);
      end
    end
    if (int'(q_lg) > LEVELS - 1) begin
      q_k = KW'(LEVELS - 1);
    end else begin
      q_k = KW'(q_lg);
    end
  end

  assign q_base = AW'(q_k) * AW'(DEPTH);
  assign q_a    = q_base + AW'(in_left);
  assign q_b    = q_base + AW'(in_right) + AW'(1) - (AW'(1) << q_k);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_addr_r;
    mem_wd = rd_min;
    if (cmd.push && push_room) begin
      mem_we = 1'b1;
      mem_wa = AW'(push_idx);
      mem_wd = in_value;
    end else if (wpend_r) begin
      mem_we = 1'b1;
    end
    mem_re = cmd.bld_step || (cmd.query && !q_err);
    mem_ra = cmd.bld_step ? bld_a : q_a;
    mem_rb = cmd.bld_step ? bld_b : q_b;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_a_r <= mem[mem_ra];
      rd_b_r <= mem[mem_rb];
    end
  end

  always_comb begin
    count_nxt     = count_r;
    tbl_ready_nxt = tbl_ready_r;
    lvl_nxt       = lvl_r;
    idx_nxt       = idx_r;
    if (cmd.push) begin
      count_nxt     = push_room ? push_idx + CW'(1) : push_idx;
      tbl_ready_nxt = 1'b0;
    end
    if (cmd.bld_start) begin
      lvl_nxt = KW'(1);
      idx_nxt = '0;
    end
    if (cmd.bld_step) begin
      idx_nxt = idx_r + IW'(1);
    end
    if (cmd.next_level) begin
      lvl_nxt = lvl_r + KW'(1);
      idx_nxt = '0;
    end
    if (cmd.bld_done) begin
      tbl_ready_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      tbl_ready_r <= 1'b0;
      lvl_r       <= '0;
      idx_r       <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      tbl_ready_r <= tbl_ready_nxt;
      lvl_r       <= lvl_nxt;
      idx_r       <= idx_nxt;
      wpend_r     <= cmd.bld_step;
      if (cmd.qload) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bld_step) begin
      wr_addr_r <= bld_w;
    end
    if (cmd.query) begin
      qerr_r <= q_err;
    end
    if (cmd.qload) begin
      out_min_value_r <= qerr_r ? '0 : rd_min;
      out_error_r     <= qerr_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_value_r;
  assign out_error     = out_error_r;

endmodule

/* rtl/sparse_table_range_minimum_top.sv */
// Sparse-table range-minimum engine. A query is accepted in S_IDLE, where its operands
// and error flag are registered; in S_QRES the result is loaded into the output register.
// The push marked last starts the build, which holds off input until the table is built,
// one table entry per cycle within each level through the two read ports of the table
// memory. Reset (rst_n, synchronous) empties the array and marks the table as not built;
// the table memory itself is not cleared.
module sparse_table_range_minimum_top import stm_pkg::*; #(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  stm_in_if.sink    in_ch,
  stm_out_if.source out_ch
);

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     in_ready;

  stm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_last  (in_ch.last),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stm_datapath #(
    .DEPTH  (DEPTH),
    .LEVELS (LEVELS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_value      (in_ch.value),
    .in_left       (in_ch.left),
    .in_right      (in_ch.right),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_min_value (out_ch.min_value),
    .out_error     (out_ch.error)
  );

  assign in_ch.ready = in_ready;

endmodule

/* rtl/stm_checker.sv */
// Port-level checks for the range-minimum engine, bound to the top level.
// Depends on stm_pkg for widths and function codes.
module stm_checker import stm_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_func,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [VAL_W-1:0] out_min_value,
  input logic                    out_error
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A result that is not taken stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_min_value) && $stable(out_error))
    else $error("result item changed while stalled");

  // An error result carries a zero minimum.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_min_value == '0)
    else $error("error result with nonzero min_value");

  // A query item yields a result: out_valid rises once the output register is loaded in S_QRES.
  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_func == FUNC_QUERY |-> ##2 out_valid)
    else $error("query item produced no result");

  // A push item never produces a result.
  a_push_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_func == FUNC_PUSH && !out_valid |=> !out_valid)
    else $error("push item produced a result");

endmodule

bind sparse_table_range_minimum_top stm_checker u_stm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_func       (in_ch.func),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_min_value (out_ch.min_value),
  .out_error     (out_ch.error)
);
